FILE: src/mvm_pkg.sv
package mvm_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int ADDR_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNT_W       = $clog2(2 * MAX_COLUMNS);
    localparam int QUEUE_DEPTH = 2;

    localparam int ELEM_W  = 16;
    localparam int IDX_W   = 8;
    localparam int VLEN_W  = 9;
    localparam int SUM_W   = 40;
    localparam int PROD_W  = 32;
    localparam int ROW_W   = 16;

    localparam logic [VLEN_W-1:0] VLEN_RESET = 9'd256;
    localparam logic [CNT_W-1:0]  COUNT_CAP  = CNT_W'(2 * MAX_COLUMNS - 1);

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    // one matrix element on its way from the front part to the back part
    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic [ELEM_W-1:0] vec;
        logic              in_range;
        logic              first;
        logic              row_end;
        logic              err;
        logic [ROW_W-1:0]  row_index;
    } mvm_item_t;

endpackage

FILE: src/mvm_ram.sv
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/mvm_front.sv
module mvm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [mvm_pkg::VLEN_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic [mvm_pkg::IDX_W-1:0]   vec_index,
    input  logic [mvm_pkg::ELEM_W-1:0]  elem_value,
    input  logic                        row_end,
    output logic                        push_valid,
    output mvm_pkg::mvm_item_t          push_item,
    input  logic                        push_full
);

    logic [mvm_pkg::VLEN_W-1:0] vlen_reg;
    logic [mvm_pkg::CNT_W-1:0]  col_reg, col_next;
    logic [mvm_pkg::ROW_W-1:0]  row_reg, row_next;
    logic                       s1_valid_reg, s1_valid_next;
    mvm_pkg::mvm_item_t         s1_item_reg, s1_item_next;

    logic                       accept;
    logic                       is_load;
    logic                       is_matrix;
    logic                       wr_en;
    logic [mvm_pkg::CNT_W-1:0]  col_inc;
    logic                       err;
    logic [mvm_pkg::ELEM_W-1:0] vec_rd;

    assign in_stall  = s1_valid_reg && push_full;
    assign accept    = in_valid && !in_stall;
    assign is_load   = accept && (cmd == mvm_pkg::CMD_LOAD);
    assign is_matrix = accept && (cmd == mvm_pkg::CMD_MATRIX);
    assign wr_en     = is_load && (32'(vec_index) < mvm_pkg::MAX_COLUMNS);

    mvm_ram #(
        .WIDTH (mvm_pkg::ELEM_W),
        .DEPTH (mvm_pkg::MAX_COLUMNS)
    ) u_vec_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (mvm_pkg::ADDR_W'(vec_index)),
        .wdata (elem_value),
        .re    (is_matrix),
        .raddr (col_reg[mvm_pkg::ADDR_W-1:0]),
        .rdata (vec_rd)
    );

    always_comb
    begin
        col_inc = (col_reg < mvm_pkg::COUNT_CAP) ? col_reg + 1'b1 : col_reg;
        err     = (32'(col_inc) != 32'(vlen_reg)) ||
                  (32'(vlen_reg) > mvm_pkg::MAX_COLUMNS);

        col_next = col_reg;
        row_next = row_reg;
        if (is_load)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (is_matrix)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_inc;
            end
        end

        s1_valid_next = s1_valid_reg;
        if (s1_valid_reg && !push_full)
        begin
            s1_valid_next = 1'b0;
        end
        if (is_matrix)
        begin
            s1_valid_next = 1'b1;
        end

        s1_item_next = s1_item_reg;
        if (is_matrix)
        begin
            s1_item_next.elem      = elem_value;
            s1_item_next.vec       = '0;
            s1_item_next.in_range  = (32'(col_reg) < mvm_pkg::MAX_COLUMNS);
            s1_item_next.first     = (col_reg == '0);
            s1_item_next.row_end   = row_end;
            s1_item_next.err       = err;
            s1_item_next.row_index = row_reg;
        end

        push_valid    = s1_valid_reg;
        push_item     = s1_item_reg;
        push_item.vec = vec_rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg     <= mvm_pkg::VLEN_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                vlen_reg <= cfg_data;
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

endmodule

FILE: src/mvm_queue.sv
module mvm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  mvm_pkg::mvm_item_t push_item,
    output logic               full,
    output logic               pop_valid,
    output mvm_pkg::mvm_item_t pop_item,
    input  logic               pop_ready
);

    localparam int PTR_W = (mvm_pkg::QUEUE_DEPTH > 1) ? $clog2(mvm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mvm_pkg::QUEUE_DEPTH + 1);

    mvm_pkg::mvm_item_t slot_reg [mvm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;

    assign full      = (32'(count_reg) == mvm_pkg::QUEUE_DEPTH);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rptr_reg];
    assign push      = push_valid && !full;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (push)
        begin
            wptr_next = (32'(wptr_reg) == mvm_pkg::QUEUE_DEPTH - 1) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (32'(rptr_reg) == mvm_pkg::QUEUE_DEPTH - 1) ? '0 : rptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/mvm_back.sv
module mvm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    input  mvm_pkg::mvm_item_t                pop_item,
    output logic                              pop_ready,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mvm_pkg::SUM_W-1:0]  row_sum,
    output logic [mvm_pkg::ROW_W-1:0]         row_index,
    output logic                              size_error
);

    localparam logic signed [mvm_pkg::SUM_W-1:0] ACC_MAX = {1'b0, {(mvm_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [mvm_pkg::SUM_W-1:0] ACC_MIN = {1'b1, {(mvm_pkg::SUM_W-1){1'b0}}};

    // multiply stage
    logic                               mul_valid_reg, mul_valid_next;
    logic signed [mvm_pkg::PROD_W-1:0]  prod_reg;
    logic                               mul_in_range_reg;
    logic                               mul_first_reg;
    logic                               mul_row_end_reg;
    logic                               mul_err_reg;
    logic [mvm_pkg::ROW_W-1:0]          mul_row_reg;

    // accumulate and result stage
    logic signed [mvm_pkg::SUM_W-1:0]   acc_reg, acc_next;
    logic                               out_valid_reg, out_valid_next;
    logic signed [mvm_pkg::SUM_W-1:0]   row_sum_reg;
    logic [mvm_pkg::ROW_W-1:0]          row_index_reg;
    logic                               size_error_reg;

    logic                               out_free;
    logic                               retire;
    logic                               load_mul;
    logic signed [mvm_pkg::SUM_W-1:0]   base;
    logic signed [mvm_pkg::SUM_W:0]     sum_wide;

    assign out_free  = !out_valid_reg || !out_stall;
    assign retire    = mul_valid_reg && (!mul_row_end_reg || out_free);
    assign pop_ready = !mul_valid_reg || retire;
    assign load_mul  = pop_valid && pop_ready;

    always_comb
    begin
        base     = mul_first_reg ? '0 : acc_reg;
        sum_wide = (mvm_pkg::SUM_W+1)'(base) +
                   (mul_in_range_reg ? (mvm_pkg::SUM_W+1)'(prod_reg) : '0);
        if (sum_wide[mvm_pkg::SUM_W] != sum_wide[mvm_pkg::SUM_W-1])
        begin
            acc_next = sum_wide[mvm_pkg::SUM_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_next = sum_wide[mvm_pkg::SUM_W-1:0];
        end

        mul_valid_next = mul_valid_reg;
        if (retire)
        begin
            mul_valid_next = 1'b0;
        end
        if (load_mul)
        begin
            mul_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (retire && mul_row_end_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
            if (retire)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            prod_reg         <= $signed(pop_item.elem) * $signed(pop_item.vec);
            mul_in_range_reg <= pop_item.in_range;
            mul_first_reg    <= pop_item.first;
            mul_row_end_reg  <= pop_item.row_end;
            mul_err_reg      <= pop_item.err;
            mul_row_reg      <= pop_item.row_index;
        end
        if (retire && mul_row_end_reg)
        begin
            row_sum_reg    <= mul_err_reg ? '0 : acc_next;
            row_index_reg  <= mul_row_reg;
            size_error_reg <= mul_err_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_sum    = row_sum_reg;
    assign row_index  = row_index_reg;
    assign size_error = size_error_reg;

endmodule

FILE: src/matrix_vector_multiply.sv
// path: a row-closing matrix element reaches its result through the vector ram read,
// the queue, the multiply register and the accumulate into the result register
// throughput: one item per cycle while out_stall is low, set by the single multiply-accumulate
// reset: rst_n clears counters, queue, accumulator and valids; vector_length returns to 256
// the vector ram is not cleared and reads undefined until written
module matrix_vector_multiply (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: vector_length
    input  logic                              cfg_write,
    input  logic [mvm_pkg::VLEN_W-1:0]        cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [mvm_pkg::IDX_W-1:0]         vec_index,
    input  logic signed [mvm_pkg::ELEM_W-1:0] elem_value,
    input  logic                              row_end,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mvm_pkg::SUM_W-1:0]  row_sum,
    output logic [mvm_pkg::ROW_W-1:0]         row_index,
    output logic                              size_error
);

    // front to queue
    logic               push_valid;
    mvm_pkg::mvm_item_t push_item;
    logic               push_full;

    // queue to back
    logic               pop_valid;
    mvm_pkg::mvm_item_t pop_item;
    logic               pop_ready;

    // front part: vector loads go straight into the ram, matrix elements
    // get their column, row number and length check, and read the vector entry
    mvm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .vec_index  (vec_index),
        .elem_value (elem_value),
        .row_end    (row_end),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_full  (push_full)
    );

    // short queue so a stalled result does not stop input transfers at once
    mvm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (push_full),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    // back part: registered multiply, then saturating accumulate; the first
    // element of a row restarts the sum, the last one loads the result register
    mvm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_sum    (row_sum),
        .row_index  (row_index),
        .size_error (size_error)
    );

endmodule
